>>> sv/rotate_and_project_vertex_defines.svh
// Assertion macros shared by the checkers of the vertex rotation and projection block.
// No dependencies. Each macro expects clk and rst to be visible where it is used.
`ifndef ROTATE_AND_PROJECT_VERTEX_DEFINES_SVH
`define ROTATE_AND_PROJECT_VERTEX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotate_and_project_vertex: implication check failed");

// The consequent must hold after the antecedent, delayed by the argument n.
`define RVP_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("rotate_and_project_vertex: delayed check failed");

`endif

>>> sv/rvp_pkg.sv
// Shared types, constants and register indexes of the vertex rotation and projection block.
// No dependencies; every other file of the block but the defines header imports it.
`default_nettype none

package rvp_pkg;

  // Fixed-point formats.
  localparam int TRIG_SHIFT  = 14;
  localparam int SCALE_SHIFT = 8;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF    = 10;
  localparam int SCREEN_OFFSET_DEF = 150;

  // Cycles from an accepted item to its result strobe.
  localparam int LATENCY = 8;

  typedef logic signed [15:0] rvp_trig_t;
  typedef logic        [15:0] rvp_scale_t;

  typedef enum logic [3:0] {
    REG_COS_X   = 4'd0,
    REG_SIN_X   = 4'd1,
    REG_COS_Y   = 4'd2,
    REG_SIN_Y   = 4'd3,
    REG_COS_Z   = 4'd4,
    REG_SIN_Z   = 4'd5,
    REG_SCALE_H = 4'd6,
    REG_SCALE_V = 4'd7
  } rvp_reg_t;

  // Register values after reset: identity rotation, unit scale.
  localparam rvp_trig_t  TRIG_ONE  = 16'sd16384;
  localparam rvp_trig_t  TRIG_ZERO = 16'sd0;
  localparam rvp_scale_t SCALE_ONE = 16'd256;

  function automatic int rvp_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> sv/rvp_rotate.sv
// One plane rotation: p = (a*c + b*s) >>> 14 and q = (b*c - a*s) >>> 14, two stages.
// Depends on rvp_pkg.
`default_nettype none

module rvp_rotate #(
  parameter int AW = 17,
  parameter int BW = 16,
  parameter int OW = 19
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  input  rvp_pkg::rvp_trig_t   c,
  input  rvp_pkg::rvp_trig_t   s,
  output logic                 out_valid,
  output logic signed [OW-1:0] p,
  output logic signed [OW-1:0] q
);
  import rvp_pkg::*;

  localparam int IW = rvp_max(AW, BW);
  localparam int PW = IW + 16;

  logic signed [IW-1:0] a_ext;
  logic signed [IW-1:0] b_ext;
  logic signed [PW-1:0] ac;
  logic signed [PW-1:0] bs;
  logic signed [PW-1:0] bc;
  logic signed [PW-1:0] as_prod;
  logic                 prod_valid;
  logic signed [PW:0]   sum_p;
  logic signed [PW:0]   sum_q;
  logic signed [PW:0]   shr_p;
  logic signed [PW:0]   shr_q;

  assign a_ext = IW'(a);
  assign b_ext = IW'(b);

  // Stage one: the four products.
  always_ff @(posedge clk) begin
    ac      <= a_ext * c;
    bs      <= b_ext * s;
    bc      <= b_ext * c;
    as_prod <= a_ext * s;
  end

  // Stage two: sums, floor shift back to integer.
  assign sum_p = (PW+1)'(ac) + (PW+1)'(bs);
  assign sum_q = (PW+1)'(bc) - (PW+1)'(as_prod);
  assign shr_p = sum_p >>> TRIG_SHIFT;
  assign shr_q = sum_q >>> TRIG_SHIFT;

  always_ff @(posedge clk) begin
    p <= shr_p[OW-1:0];
    q <= shr_q[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

endmodule

`default_nettype wire

>>> sv/rvp_project.sv
// Screen projection: scale by Q8.8 factors, shift, add the offset and saturate, two stages.
// Depends on rvp_pkg.
`default_nettype none

module rvp_project #(
  parameter int W      = 25,
  parameter int OFFSET = 150
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] x2,
  input  logic signed [W-1:0] y2,
  input  rvp_pkg::rvp_scale_t scale_h,
  input  rvp_pkg::rvp_scale_t scale_v,
  output logic                done,
  output logic signed [15:0]  screen_x,
  output logic signed [15:0]  screen_y
);
  import rvp_pkg::*;

  localparam int PW = W + 17;
  localparam int TW = W + 10;
  localparam logic signed [TW-1:0] OFF    = TW'(OFFSET);
  localparam logic signed [TW-1:0] SAT_HI = TW'(32767);
  localparam logic signed [TW-1:0] SAT_LO = -TW'(32768);

  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic                 prod_valid;
  logic signed [TW-1:0] pos_x;
  logic signed [TW-1:0] pos_y;
  logic signed [15:0]   sat_x;
  logic signed [15:0]   sat_y;

  always_ff @(posedge clk) begin
    prod_x <= x2 * $signed({1'b0, scale_h});
    prod_y <= y2 * $signed({1'b0, scale_v});
  end

  assign pos_x = TW'(prod_x >>> SCALE_SHIFT) + OFF;
  assign pos_y = TW'(prod_y >>> SCALE_SHIFT) + OFF;

  always_comb begin
    if (pos_x > SAT_HI) begin
      sat_x = 16'sh7fff;
    end else if (pos_x < SAT_LO) begin
      sat_x = -16'sh8000;
    end else begin
      sat_x = pos_x[15:0];
    end
    if (pos_y > SAT_HI) begin
      sat_y = 16'sh7fff;
    end else if (pos_y < SAT_LO) begin
      sat_y = -16'sh8000;
    end else begin
      sat_y = pos_y[15:0];
    end
  end

  always_ff @(posedge clk) begin
    screen_x <= sat_x;
    screen_y <= sat_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      done       <= prod_valid;
    end
  end

endmodule

`default_nettype wire

>>> sv/rotate_and_project_vertex.sv
// Throughput: one item per cycle while busy is low; the pipeline never stalls, as results cannot be held off.
// Four multiply-then-sum sections (X, Y and Z rotation, projection) of two stages each.
// Reset is synchronous and active high: it empties the pipeline, loads the identity
// rotation and unit scale, and holds busy high for the cycle after it is released.
`default_nettype none

module rotate_and_project_vertex #(
  parameter int COORD_BITS    = rvp_pkg::COORD_BITS_DEF,
  parameter int SCREEN_OFFSET = rvp_pkg::SCREEN_OFFSET_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] grid_col,
  input  logic [COORD_BITS-1:0] grid_row,
  input  logic signed [15:0]    height_value,
  output logic                  done,
  output logic signed [15:0]    screen_x,
  output logic signed [15:0]    screen_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import rvp_pkg::*;

  // Widths grow by three bits per rotation: one for the sum, two because a
  // register may hold up to -32768, twice the Q1.14 unit.
  localparam int CW = COORD_BITS + 1;
  localparam int R1 = rvp_max(CW, 16) + 3;
  localparam int R2 = R1 + 3;
  localparam int R3 = R2 + 3;

  rvp_trig_t  cos_x;
  rvp_trig_t  sin_x;
  rvp_trig_t  cos_y;
  rvp_trig_t  sin_y;
  rvp_trig_t  cos_z;
  rvp_trig_t  sin_z;
  rvp_scale_t scale_h;
  rvp_scale_t scale_v;

  logic                 accept;
  logic signed [CW-1:0] x_in;
  logic signed [CW-1:0] y_in;
  logic signed [CW-1:0] x_d1;
  logic signed [CW-1:0] x_d2;
  logic                 rx_valid;
  logic signed [R1-1:0] y0;
  logic signed [R1-1:0] z0;
  logic signed [R1-1:0] y0_d1;
  logic signed [R1-1:0] y0_d2;
  logic                 ry_valid;
  logic signed [R2-1:0] x1;
  logic                 rz_valid;
  logic signed [R3-1:0] x2;
  logic signed [R3-1:0] y2;

  // The configuration port is always ready. The user must write only while the pipeline
  // is empty (the block does not enforce this); every stage reads the live registers directly.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_x   <= TRIG_ONE;
      sin_x   <= TRIG_ZERO;
      cos_y   <= TRIG_ONE;
      sin_y   <= TRIG_ZERO;
      cos_z   <= TRIG_ONE;
      sin_z   <= TRIG_ZERO;
      scale_h <= SCALE_ONE;
      scale_v <= SCALE_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COS_X:   cos_x   <= $signed(cfg_data);
        REG_SIN_X:   sin_x   <= $signed(cfg_data);
        REG_COS_Y:   cos_y   <= $signed(cfg_data);
        REG_SIN_Y:   sin_y   <= $signed(cfg_data);
        REG_COS_Z:   cos_z   <= $signed(cfg_data);
        REG_SIN_Z:   sin_z   <= $signed(cfg_data);
        REG_SCALE_H: scale_h <= cfg_data;
        REG_SCALE_V: scale_v <= cfg_data;
        default: ;
      endcase
    end
  end

  // Busy only marks the cycle after reset; the pipeline itself takes an
  // item in every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  // Grid coordinates are unsigned; a zero sign bit makes them signed operands.
  assign x_in = $signed({1'b0, grid_col});
  assign y_in = $signed({1'b0, grid_row});

  // Rotation about X: y0 = (y*cx + h*sx) >>> 14, z0 = (h*cx - y*sx) >>> 14.
  rvp_rotate #(
    .AW (CW),
    .BW (16),
    .OW (R1)
  ) u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .a         (y_in),
    .b         (height_value),
    .c         (cos_x),
    .s         (sin_x),
    .out_valid (rx_valid),
    .p         (y0),
    .q         (z0)
  );

  // The column bypasses the X rotation and is delayed through x_d1 and x_d2 to meet z0.
  always_ff @(posedge clk) begin
    x_d1 <= x_in;
    x_d2 <= x_d1;
  end

  // Rotation about Y: only x1 = (x*cy - z0*sy) >>> 14 is needed further on.
  rvp_rotate #(
    .AW (R1),
    .BW (CW),
    .OW (R2)
  ) u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx_valid),
    .a         (z0),
    .b         (x_d2),
    .c         (cos_y),
    .s         (sin_y),
    .out_valid (ry_valid),
    .p         (),
    .q         (x1)
  );

  // y1 equals y0; it is delayed to meet x1.
  always_ff @(posedge clk) begin
    y0_d1 <= y0;
    y0_d2 <= y0_d1;
  end

  // Rotation about Z: x2 = (x1*cz + y1*sz) >>> 14, y2 = (y1*cz - x1*sz) >>> 14.
  rvp_rotate #(
    .AW (R2),
    .BW (R1),
    .OW (R3)
  ) u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ry_valid),
    .a         (x1),
    .b         (y0_d2),
    .c         (cos_z),
    .s         (sin_z),
    .out_valid (rz_valid),
    .p         (x2),
    .q         (y2)
  );

  // Projection to the screen with saturation to signed 16 bits.
  rvp_project #(
    .W      (R3),
    .OFFSET (SCREEN_OFFSET)
  ) u_project (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rz_valid),
    .x2       (x2),
    .y2       (y2),
    .scale_h  (scale_h),
    .scale_v  (scale_v),
    .done     (done),
    .screen_x (screen_x),
    .screen_y (screen_y)
  );

endmodule

`default_nettype wire

>>> sv/rotate_and_project_vertex_checker.sv
// Port-level checks of the vertex rotation and projection block, bound to its top level.
// Depends on rvp_pkg and rotate_and_project_vertex_defines.svh.
`default_nettype none

`include "rotate_and_project_vertex_defines.svh"

module rotate_and_project_vertex_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready
);
  import rvp_pkg::*;

  // Every accepted item yields its result after the delay given by LATENCY.
  `RVP_ASSERT_DLY(a_item_done, start && !busy, LATENCY, done)

  // No result appears without an item accepted the LATENCY delay earlier.
  `RVP_ASSERT_IMP(a_done_has_item, done, $past(start && !busy, LATENCY))

  // Once reset has been sampled low, both channels stay open.
  `RVP_ASSERT_IMP(a_open_after_reset, $past(!rst), !busy && cfg_ready)

endmodule

bind rotate_and_project_vertex rotate_and_project_vertex_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
